// File: rtl/nnds_pkg.sv
// Shared types and constants for the nearest neighbor downscaler.
`timescale 1ns / 1ps
`default_nettype none

package nnds_pkg;

   localparam int DEFAULT_MAX_DIM    = 4096;
   localparam int DEFAULT_RATIO_BITS = 8;

   localparam int DIM_REG_W  = 13;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int RESET_SOURCE_WIDTH  = 1280;
   localparam int RESET_SOURCE_HEIGHT = 720;
   localparam int RESET_NUMERATOR     = 1;
   localparam int RESET_DENOMINATOR   = 2;

   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH  = 2'd0,
      REG_SOURCE_HEIGHT = 2'd1,
      REG_NUMERATOR     = 2'd2,
      REG_DENOMINATOR   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       row_end;
      logic [1:0] pad_count;
      logic       frame_end;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: rtl/nearest_neighbor_downscaler_top.sv
// Top level of the nearest neighbor downscaler: pixel selection and result buffer.
//
//   channel   direction   handshake                 payload
//   req_      in          req_valid / req_stall     req_data  (one source pixel)
//   rsp_      out         rsp_valid / rsp_stall     rsp_data  (one kept pixel)
//   csr_      in          APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One source pixel is taken per cycle while req_stall is low; a kept pixel is registered before it shows on rsp_.
// Selection is a single pass of adds and compares against running sums.
// A two-entry result buffer (output register plus skid) lets a pixel be taken
// while the previous result waits; req_stall rises only when both entries hold.
// Synchronous reset returns to the first pixel of a frame with default config.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_downscaler_top #(
   parameter int MAX_DIM    = nnds_pkg::DEFAULT_MAX_DIM,
   parameter int RATIO_BITS = nnds_pkg::DEFAULT_RATIO_BITS
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire nnds_pkg::req_payload_type     req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output nnds_pkg::rsp_payload_type          rsp_data,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [nnds_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [nnds_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nnds_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import nnds_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int SUM_W = DIM_W + RATIO_BITS + 1;

   // configuration registers
   logic [DIM_REG_W-1:0]  width_ff, height_ff;
   logic [RATIO_BITS-1:0] num_ff, den_ff;
   reg_index_type         csr_index;
   logic                  csr_write;

   // frame position state
   logic [DIM_W-1:0] src_column_ff, src_column_in, src_row_ff, src_row_in;
   logic [SUM_W-1:0] col_tgt_ff, col_tgt_in, col_src_ff, col_src_in;
   logic [SUM_W-1:0] row_tgt_ff, row_tgt_in, row_src_ff, row_src_in;
   logic [1:0]       out_col_low_ff, out_col_low_in;
   logic             row_sel_ff, row_sel_in;

   // result buffer
   logic            out_valid_ff, skid_valid_ff;
   rsp_payload_type out_data_ff, skid_data_ff;

   logic [DIM_W-1:0]      sw, sh, col_next, row_next;
   logic [RATIO_BITS-1:0] den_r, num_r;
   logic [SUM_W-1:0]      den, num, wlimit, hlimit;
   logic                  row_sel_now, keep, last_col, last_row, col_wrap, row_wrap;
   logic                  accept, push, out_pop;
   rsp_payload_type       result;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_index)
         REG_SOURCE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_SOURCE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_NUMERATOR:     csr_prdata = CSR_DATA_W'(num_ff);
         REG_DENOMINATOR:   csr_prdata = CSR_DATA_W'(den_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_REG_W'(RESET_SOURCE_WIDTH);
         height_ff <= DIM_REG_W'(RESET_SOURCE_HEIGHT);
         num_ff    <= RATIO_BITS'(RESET_NUMERATOR);
         den_ff    <= RATIO_BITS'(RESET_DENOMINATOR);
      end else if (csr_write) begin
         case (csr_index)
            REG_SOURCE_WIDTH:  width_ff  <= csr_pwdata[DIM_REG_W-1:0];
            REG_SOURCE_HEIGHT: height_ff <= csr_pwdata[DIM_REG_W-1:0];
            REG_NUMERATOR:     num_ff    <= csr_pwdata[RATIO_BITS-1:0];
            REG_DENOMINATOR:   den_ff    <= csr_pwdata[RATIO_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry; ratios above one become a plain copy
   always_comb begin
      sw     = clamp_dim(width_ff);
      sh     = clamp_dim(height_ff);
      den_r  = (den_ff == '0) ? RATIO_BITS'(1) : den_ff;
      num_r  = (num_ff > den_r) ? den_r : num_ff;
      den    = SUM_W'(den_r);
      num    = SUM_W'(num_r);
      wlimit = SUM_W'(sw) * SUM_W'(num_r);
      hlimit = SUM_W'(sh) * SUM_W'(num_r);
   end

   // handshake
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_pop   = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // pixel selection
   always_comb begin
      if (src_column_ff == '0) begin
         row_sel_now = (row_tgt_ff < row_src_ff + num) && (row_tgt_ff + den <= hlimit);
      end else begin
         row_sel_now = row_sel_ff;
      end
      keep     = row_sel_now && (col_tgt_ff < col_src_ff + num) &&
                 (col_tgt_ff + den <= wlimit);
      last_col = (col_tgt_ff + (den << 1)) > wlimit;
      last_row = (row_tgt_ff + (den << 1)) > hlimit;

      result.blue_out  = req_data.blue_in;
      result.green_out = req_data.green_in;
      result.red_out   = req_data.red_in;
      result.row_end   = last_col;
      result.pad_count = last_col ? (out_col_low_ff + 2'd1) : 2'd0;
      result.frame_end = last_col && last_row;
      push             = accept && keep;

      col_next = src_column_ff + DIM_W'(1);
      row_next = src_row_ff + DIM_W'(1);
      col_wrap = col_next >= sw;
      row_wrap = row_next >= sh;

      src_column_in  = col_next;
      src_row_in     = src_row_ff;
      col_tgt_in     = keep ? col_tgt_ff + den : col_tgt_ff;
      col_src_in     = col_src_ff + num;
      row_tgt_in     = row_tgt_ff;
      row_src_in     = row_src_ff;
      out_col_low_in = keep ? out_col_low_ff + 2'd1 : out_col_low_ff;
      row_sel_in     = row_sel_now;
      if (col_wrap) begin
         src_column_in  = '0;
         col_tgt_in     = '0;
         col_src_in     = '0;
         out_col_low_in = '0;
         row_tgt_in     = row_sel_now ? row_tgt_ff + den : row_tgt_ff;
         row_src_in     = row_src_ff + num;
         src_row_in     = row_next;
         if (row_wrap) begin
            src_row_in = '0;
            row_tgt_in = '0;
            row_src_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_column_ff  <= '0;
         src_row_ff     <= '0;
         col_tgt_ff     <= '0;
         col_src_ff     <= '0;
         row_tgt_ff     <= '0;
         row_src_ff     <= '0;
         out_col_low_ff <= '0;
         row_sel_ff     <= 1'b1;
      end else if (accept) begin
         src_column_ff  <= src_column_in;
         src_row_ff     <= src_row_in;
         col_tgt_ff     <= col_tgt_in;
         col_src_ff     <= col_src_in;
         row_tgt_ff     <= row_tgt_in;
         row_src_ff     <= row_src_in;
         out_col_low_ff <= out_col_low_in;
         row_sel_ff     <= row_sel_in;
      end
   end

   // result buffer: output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !out_pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !out_pop) begin
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end
   end

   // checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_pad_only_at_row_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.row_end) |-> (out_data_ff.pad_count == 2'd0))
      else $error("pad count set on a pixel that does not end a row");

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.frame_end) |-> out_data_ff.row_end)
      else $error("frame end without row end");

   a_row_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && col_wrap) |=> (src_column_ff == '0 && col_tgt_ff == '0 &&
                                out_col_low_ff == 2'd0))
      else $error("column state not cleared at end of source row");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench for the nearest neighbor downscaler: directed and random pixel streams.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import nnds_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int RANDOM_PIXELS = 900;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   nearest_neighbor_downscaler_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [DIM_REG_W-1:0] cfg_width  = DIM_REG_W'(RESET_SOURCE_WIDTH);
   logic [DIM_REG_W-1:0] cfg_height = DIM_REG_W'(RESET_SOURCE_HEIGHT);
   logic [7:0]           cfg_num    = 8'(RESET_NUMERATOR);
   logic [7:0]           cfg_den    = 8'(RESET_DENOMINATOR);

   // predictor scan position and running sums
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   int unsigned col_out_sum = 0;
   int unsigned col_in_sum = 0;
   int unsigned row_out_sum = 0;
   int unsigned row_in_sum = 0;
   logic [1:0]  out_col_phase = 2'd0;
   logic        row_kept = 1'b1;

   rsp_payload_type kept_pixels[$];
   int errors = 0;
   int pixels_sent = 0;
   int burst_left = 0;
   int quiet_cycles = 0;
   int stall_count = 0;
   int stall_mode = 0;

   function automatic int unsigned clamp_dim(input logic [DIM_REG_W-1:0] v);
      if (v == '0) return 1;
      if (32'(v) > DEFAULT_MAX_DIM) return DEFAULT_MAX_DIM;
      return 32'(v);
   endfunction

   // decide whether this source pixel lands in the output, queue it if so
   task automatic select_pixel(input req_payload_type px);
      int unsigned sw, sh, den, num, wlim, hlim;
      logic keep, last_col, last_row;
      rsp_payload_type r;
      sw = clamp_dim(cfg_width);
      sh = clamp_dim(cfg_height);
      den = (cfg_den == '0) ? 1 : 32'(cfg_den);
      num = (32'(cfg_num) > den) ? den : 32'(cfg_num);
      wlim = sw * num;
      hlim = sh * num;
      if (col_pos == 0)
         row_kept = (row_out_sum < row_in_sum + num) && (row_out_sum + den <= hlim);
      keep = row_kept && (col_out_sum < col_in_sum + num) && (col_out_sum + den <= wlim);
      if (keep) begin
         last_col = col_out_sum + 2 * den > wlim;
         last_row = row_out_sum + 2 * den > hlim;
         r.blue_out  = px.blue_in;
         r.green_out = px.green_in;
         r.red_out   = px.red_in;
         r.row_end   = last_col;
         r.pad_count = last_col ? out_col_phase + 2'd1 : 2'd0;
         r.frame_end = last_col && last_row;
         kept_pixels.push_back(r);
         col_out_sum += den;
         out_col_phase += 2'd1;
      end
      col_in_sum += num;
      col_pos++;
      if (col_pos >= sw) begin
         col_pos = 0;
         col_in_sum = 0;
         col_out_sum = 0;
         out_col_phase = 2'd0;
         if (row_kept) row_out_sum += den;
         row_in_sum += num;
         row_pos++;
         if (row_pos >= sh) begin
            row_pos = 0;
            row_in_sum = 0;
            row_out_sum = 0;
         end
      end
   endtask

   // pixels left until the scan wraps to a new frame, -1 if the position is off the frame
   function automatic int frame_left();
      int unsigned sw, sh;
      sw = clamp_dim(cfg_width);
      sh = clamp_dim(cfg_height);
      if (col_pos >= sw || row_pos >= sh) return -1;
      return int'((sh - row_pos) * sw - col_pos);
   endfunction

   task automatic send_pixel(input req_payload_type px);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_stall !== 1'b0);
      select_pixel(px);
      pixels_sent++;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_pixel(req_payload_type'($urandom_range(0, 24'hFFFFFF)));
   endtask

   // stop the stream and wait until the block has nothing in flight
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (kept_pixels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic write_reg(input reg_index_type idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] stored;
      if (idx == REG_SOURCE_WIDTH || idx == REG_SOURCE_HEIGHT)
         stored = value & ((1 << DIM_REG_W) - 1);
      else
         stored = value & 8'hFF;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_SOURCE_WIDTH:  cfg_width = stored[DIM_REG_W-1:0];
         REG_SOURCE_HEIGHT: cfg_height = stored[DIM_REG_W-1:0];
         REG_NUMERATOR:     cfg_num = stored[7:0];
         REG_DENOMINATOR:   cfg_den = stored[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== stored) begin
         errors++;
         $display("%0t: register %s readback, expected %0h, actual %0h",
                  $time, idx.name(), stored, csr_prdata);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_format(input int unsigned w, input int unsigned h,
                             input int unsigned n, input int unsigned d);
      drain();
      write_reg(REG_SOURCE_WIDTH, w);
      write_reg(REG_SOURCE_HEIGHT, h);
      write_reg(REG_NUMERATOR, n);
      write_reg(REG_DENOMINATOR, d);
   endtask

   task automatic test_extreme_pixels();
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hAA55AA);
      send_pixel(24'h55AA55);
   endtask

   // scan is past column 3 of a wide row; shrinking the width ends that row at once
   task automatic test_midframe_change();
      set_format(3, 2, 1, 1);
      while (col_pos != 0 || row_pos != 0) send_random(1);
   endtask

   // ratio above one clamps to a copy; frame wraps after six pixels
   task automatic test_plain_copy();
      set_format(3, 2, 5, 3);
      send_random(6);
   endtask

   task automatic test_zero_ratio();
      set_format(2, 2, 0, 7);
      send_random(4);
      set_format(2, 1, 1, 0);
      send_random(2);
   endtask

   task automatic test_dimension_clamp();
      set_format(0, 0, 1, 1);
      send_random(2);
      set_format(13'h1FFF, 13'h1FFF, 255, 255);
      send_random(3);
   endtask

   task automatic test_random_frames();
      int kind, left, count;
      int unsigned w, h, n, d;
      while (pixels_sent < RANDOM_PIXELS + 25) begin
         kind = $urandom_range(0, 9);
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 6);
         d = $urandom_range(1, 8);
         n = $urandom_range(1, d);
         case (kind)
            6: begin
               w = $urandom_range(1, 40);
               d = $urandom_range(0, 255);
               n = $urandom_range(0, 255);
            end
            7: begin
               d = $urandom_range(1, 200);
               n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(d + 1, 255);
            end
            8: begin
               case ($urandom_range(0, 2))
                  0: w = 0;
                  1: w = DEFAULT_MAX_DIM;
                  default: w = $urandom_range(DEFAULT_MAX_DIM + 1, 13'h1FFF);
               endcase
               h = ($urandom_range(0, 3) == 0) ? 13'h1FFF : $urandom_range(0, 2);
               d = $urandom_range(0, 255);
               n = $urandom_range(0, 255);
            end
            default: ;
         endcase
         // most phases start on a frame boundary; mid-frame changes keep the scan position
         left = frame_left();
         if (kind != 9 && left > 0 && left <= 300) send_random(left);
         set_format(w, h, n, d);
         if (kind == 8)
            count = $urandom_range(1, 40);
         else
            count = int'(clamp_dim(DIM_REG_W'(w)) * clamp_dim(DIM_REG_W'(h)) *
                         $urandom_range(1, 3)
                    + (($urandom_range(0, 3) == 0) ? $urandom_range(0, w) : 0));
         send_random(count);
      end
   endtask

   // receiver stall pattern: free, light, heavy or alternating, switched now and then
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_count <= $urandom_range(20, 80);
      end else begin
         stall_count <= stall_count - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (kept_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel, expected none, actual %h", $time, rsp_data);
         end else begin
            want = kept_pixels.pop_front();
            check_field("blue_out", want.blue_out, rsp_data.blue_out);
            check_field("green_out", want.green_out, rsp_data.green_out);
            check_field("red_out", want.red_out, rsp_data.red_out);
            check_field("row_end", 8'(want.row_end), 8'(rsp_data.row_end));
            check_field("pad_count", 8'(want.pad_count), 8'(rsp_data.pad_count));
            check_field("frame_end", 8'(want.frame_end), 8'(rsp_data.frame_end));
         end
      end
   end

   // watchdog: cycles without any transfer on any port
   always @(posedge clock) begin
      if (reset === 1'b1 || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_psel && csr_penable && csr_pready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extreme_pixels();
      test_midframe_change();
      test_plain_copy();
      test_zero_ratio();
      test_dimension_clamp();
      test_random_frames();
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0 && kept_pixels.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
